/* hw/rtl/stack_machine_execute_unit_macros.svh */
// ----------------------------------------------------------------------------
// Stack machine execute unit assertion macros
// Shared property wrappers, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH
`define STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH

// same-cycle implication
`define SMX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SMX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/smx_pkg.sv */
// ----------------------------------------------------------------------------
// Stack machine execute unit package
// Widths, opcodes and status codes shared by the unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smx_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int PC_BITS     = 16;
  localparam int SP_BITS     = $clog2(STACK_DEPTH);
  localparam int CNT_BITS    = $clog2(STACK_DEPTH + 1);
  localparam int WORD_BITS   = 32;
  localparam int OP_BITS     = 5;
  localparam int STATUS_BITS = 4;
  localparam int LEN_BITS    = 16;
  localparam int DEPTH_BITS  = 11;

  typedef enum logic [OP_BITS-1:0] {
    OP_NOP   = 5'd0,
    OP_PUSH  = 5'd1,
    OP_POP   = 5'd2,
    OP_PRINT = 5'd3,
    OP_ADD   = 5'd4,
    OP_SUB   = 5'd5,
    OP_MUL   = 5'd6,
    OP_DIV   = 5'd7,
    OP_MOD   = 5'd8,
    OP_DUP   = 5'd9,
    OP_DUPI  = 5'd10,
    OP_SWAP  = 5'd11,
    OP_SWAPI = 5'd12,
    OP_CMPE  = 5'd13,
    OP_CMPNE = 5'd14,
    OP_CMPG  = 5'd15,
    OP_CMPL  = 5'd16,
    OP_CMPGE = 5'd17,
    OP_CMPLE = 5'd18,
    OP_JZ    = 5'd19,
    OP_JNZ   = 5'd20,
    OP_JMP   = 5'd21,
    OP_HALT  = 5'd22
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK   = 4'd0,
    ST_FIN  = 4'd1,
    ST_OVF  = 4'd2,
    ST_UNF  = 4'd3,
    ST_IDX  = 4'd4,
    ST_DIVZ = 4'd5,
    ST_JMP  = 4'd6,
    ST_UNK  = 4'd7,
    ST_STOP = 4'd8
  } status_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]     status;
    logic                       print_valid;
    logic signed [WORD_BITS-1:0] print_value;
    logic [LEN_BITS-1:0]        next_pc;
    logic [DEPTH_BITS-1:0]      depth_now;
  } res_t;

endpackage

/* hw/rtl/smx_if.sv */
// ----------------------------------------------------------------------------
// Stack machine execute unit channels
// Instruction request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface smx_req_if import smx_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [OP_BITS-1:0]          opcode;
  logic signed [WORD_BITS-1:0] operand;

  modport source (output valid, output opcode, output operand, input ready);
  modport sink   (input valid, input opcode, input operand, output ready);
endinterface

interface smx_rsp_if import smx_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [STATUS_BITS-1:0]      status;
  logic                        print_valid;
  logic signed [WORD_BITS-1:0] print_value;
  logic [LEN_BITS-1:0]         next_pc;
  logic [DEPTH_BITS-1:0]       depth_now;

  modport source (output valid, output status, output print_valid, output print_value,
                  output next_pc, output depth_now, input ready);
  modport sink   (input valid, input status, input print_valid, input print_value,
                  input next_pc, input depth_now, output ready);
endinterface

/* hw/rtl/smx_stack_ram.sv */
// ----------------------------------------------------------------------------
// Stack store
// One write port, two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smx_stack_ram import smx_pkg::*; (
  input  logic                 clk,
  input  logic                 we,
  input  logic [SP_BITS-1:0]   waddr,
  input  logic [WORD_BITS-1:0] wdata,
  input  logic [SP_BITS-1:0]   raddr0,
  input  logic [SP_BITS-1:0]   raddr1,
  output logic [WORD_BITS-1:0] rdata0,
  output logic [WORD_BITS-1:0] rdata1
);

  logic [WORD_BITS-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

/* hw/rtl/smx_div.sv */
// ----------------------------------------------------------------------------
// Signed divider
// Radix-2 restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smx_div import smx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] dividend,
  input  logic [WORD_BITS-1:0] divisor,
  output logic                 busy,
  output logic                 done,
  output logic [WORD_BITS-1:0] quot,
  output logic [WORD_BITS-1:0] rem
);

  localparam int ITER_BITS = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] q;
  logic [WORD_BITS-1:0] r;
  logic [WORD_BITS-1:0] d;
  logic                 neg_q;
  logic                 neg_r;
  logic [ITER_BITS-1:0] iter;
  logic [WORD_BITS+1:0] shifted;
  logic [WORD_BITS+1:0] diff;

  assign shifted = {1'b0, r, q[WORD_BITS-1]};
  assign diff    = shifted - {2'b00, d};
  assign quot    = neg_q ? (~q + 1'b1) : q;
  assign rem     = neg_r ? (~r + 1'b1) : r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q     <= dividend[WORD_BITS-1] ? (~dividend + 1'b1) : dividend;
        d     <= divisor[WORD_BITS-1] ? (~divisor + 1'b1) : divisor;
        r     <= '0;
        neg_q <= dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
        neg_r <= dividend[WORD_BITS-1];
        iter  <= ITER_BITS'(WORD_BITS);
        busy  <= 1'b1;
      end else if (busy) begin
        if (!diff[WORD_BITS+1]) begin
          r <= diff[WORD_BITS-1:0];
          q <= {q[WORD_BITS-2:0], 1'b1};
        end else begin
          r <= shifted[WORD_BITS-1:0];
          q <= {q[WORD_BITS-2:0], 1'b0};
        end
        iter <= iter - 1'b1;
        if (iter == ITER_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hw/rtl/stack_machine_execute_unit.sv */
// ----------------------------------------------------------------------------
// Stack machine execute unit
// Executes one instruction per request against a 1024-word stack held in a
// synchronous RAM. Most instructions go from acceptance to a result in the
// output register by stack read, then execute and write, then delivery.
// Swap and indexed swap write their second entry during delivery. Division and
// modulo wait in a division state for the 32-step radix-2 divider. A result
// that is not taken holds the unit in delivery. After an error, halt or end of
// program every request answers stopped until reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stack_machine_execute_unit_macros.svh"

module stack_machine_execute_unit import smx_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [LEN_BITS-1:0] cfg_wdata,
  smx_req_if.sink             req,
  smx_rsp_if.source           rsp
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV, S_FIN} state_t;

  state_t                state;
  logic [LEN_BITS-1:0]   prog_len;
  logic [CNT_BITS-1:0]   count;
  logic [PC_BITS-1:0]    pc;
  logic                  stopped;
  logic [OP_BITS-1:0]    op_r;
  logic [WORD_BITS-1:0]  opd_r;
  res_t                  res;
  logic                  w2_pend;
  logic [SP_BITS-1:0]    w2_addr;
  logic [WORD_BITS-1:0]  w2_data;

  logic                  ram_we;
  logic [SP_BITS-1:0]    ram_waddr;
  logic [WORD_BITS-1:0]  ram_wdata;
  logic [SP_BITS-1:0]    ram_raddr0;
  logic [SP_BITS-1:0]    ram_raddr1;
  logic [WORD_BITS-1:0]  a;
  logic [WORD_BITS-1:0]  b;

  logic                  div_busy;
  logic                  div_done;
  logic [WORD_BITS-1:0]  div_q;
  logic [WORD_BITS-1:0]  div_r;

  logic [CNT_BITS-1:0]   cnt_m1;
  logic [CNT_BITS-1:0]   cnt_m2;

  // execute stage
  status_t               st;
  logic                  pv;
  logic [WORD_BITS-1:0]  pval;
  logic                  jumped;
  logic [PC_BITS-1:0]    nxt;
  logic [CNT_BITS-1:0]   cnt_next;
  logic                  stop_next;
  logic                  x_we;
  logic [SP_BITS-1:0]    x_addr;
  logic [WORD_BITS-1:0]  x_data;
  logic                  x_w2;
  logic [SP_BITS-1:0]    x_w2_addr;
  logic [WORD_BITS-1:0]  x_w2_data;
  logic                  div_go;
  logic                  n_ge1;
  logic                  n_ge2;
  logic                  full;
  logic                  idx_ok;
  logic                  jmp_ok;
  logic                  take;
  logic [PC_BITS-1:0]    pc_inc;
  logic [WORD_BITS-1:0]  prod;
  logic                  flag;

  assign cnt_m1 = count - 1'b1;
  assign cnt_m2 = count - 2'd2;

  always_comb begin
    ram_raddr0 = cnt_m1[SP_BITS-1:0];
    if (op_t'(req.opcode) == OP_DUPI || op_t'(req.opcode) == OP_SWAPI) begin
      ram_raddr1 = req.operand[SP_BITS-1:0];
    end else begin
      ram_raddr1 = cnt_m2[SP_BITS-1:0];
    end
  end

  smx_stack_ram u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr0 (ram_raddr0),
    .raddr1 (ram_raddr1),
    .rdata0 (a),
    .rdata1 (b)
  );

  smx_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go && state == S_EXEC),
    .dividend (b),
    .divisor  (a),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  assign n_ge1  = count != '0;
  assign n_ge2  = count >= CNT_BITS'(2);
  assign full   = count >= CNT_BITS'(STACK_DEPTH);
  assign idx_ok = opd_r < WORD_BITS'(count);
  assign jmp_ok = opd_r < WORD_BITS'(prog_len);
  assign pc_inc = pc + 1'b1;
  assign prod   = a * b;

  always_comb begin
    st        = ST_OK;
    pv        = 1'b0;
    pval      = '0;
    jumped    = 1'b0;
    nxt       = pc_inc;
    cnt_next  = count;
    stop_next = stopped;
    x_we      = 1'b0;
    x_addr    = count[SP_BITS-1:0];
    x_data    = '0;
    x_w2      = 1'b0;
    x_w2_addr = cnt_m2[SP_BITS-1:0];
    x_w2_data = a;
    div_go    = 1'b0;
    take      = 1'b0;
    flag      = 1'b0;
    unique case (op_t'(op_r))
      OP_NOP: begin
      end
      OP_PUSH: begin
        if (full) begin
          st = ST_OVF;
        end else begin
          x_we = 1'b1; x_data = opd_r; cnt_next = count + 1'b1;
        end
      end
      OP_POP: begin
        if (!n_ge1) st = ST_UNF;
        else cnt_next = cnt_m1;
      end
      OP_PRINT: begin
        if (!n_ge1) begin
          st = ST_UNF;
        end else begin
          pv = 1'b1; pval = a;
        end
      end
      OP_ADD, OP_SUB, OP_MUL: begin
        if (!n_ge2) begin
          st = ST_UNF;
        end else begin
          x_we     = 1'b1;
          x_addr   = cnt_m2[SP_BITS-1:0];
          x_data   = (op_t'(op_r) == OP_ADD) ? a + b :
                     (op_t'(op_r) == OP_SUB) ? b - a : prod;
          cnt_next = cnt_m1;
        end
      end
      OP_DIV, OP_MOD: begin
        if (!n_ge2) st = ST_UNF;
        else if (a == '0) st = ST_DIVZ;
        else begin
          div_go = 1'b1; cnt_next = cnt_m1;
        end
      end
      OP_DUP: begin
        if (!n_ge1) st = ST_UNF;
        else if (full) st = ST_OVF;
        else begin
          x_we = 1'b1; x_data = a; cnt_next = count + 1'b1;
        end
      end
      OP_DUPI: begin
        if (!idx_ok) st = ST_IDX;
        else if (full) st = ST_OVF;
        else begin
          x_we = 1'b1; x_data = b; cnt_next = count + 1'b1;
        end
      end
      OP_SWAP: begin
        if (!n_ge2) begin
          st = ST_UNF;
        end else begin
          x_we = 1'b1; x_addr = cnt_m1[SP_BITS-1:0]; x_data = b;
          x_w2 = 1'b1; x_w2_addr = cnt_m2[SP_BITS-1:0]; x_w2_data = a;
        end
      end
      OP_SWAPI: begin
        if (!idx_ok) begin
          st = ST_IDX;
        end else begin
          x_we = 1'b1; x_addr = opd_r[SP_BITS-1:0]; x_data = a;
          x_w2 = 1'b1; x_w2_addr = cnt_m1[SP_BITS-1:0]; x_w2_data = b;
        end
      end
      OP_CMPE, OP_CMPNE, OP_CMPG, OP_CMPL, OP_CMPGE, OP_CMPLE: begin
        case (op_t'(op_r))
          OP_CMPE:  flag = $signed(a) == $signed(b);
          OP_CMPNE: flag = $signed(a) != $signed(b);
          OP_CMPG:  flag = $signed(a) >  $signed(b);
          OP_CMPL:  flag = $signed(a) <  $signed(b);
          OP_CMPGE: flag = $signed(a) >= $signed(b);
          default:  flag = $signed(a) <= $signed(b);
        endcase
        if (!n_ge2) st = ST_UNF;
        else if (full) st = ST_OVF;
        else begin
          x_we = 1'b1; x_data = WORD_BITS'(flag); cnt_next = count + 1'b1;
        end
      end
      OP_JZ, OP_JNZ: begin
        take = (op_t'(op_r) == OP_JZ) ? (a == '0) : (a != '0);
        if (!n_ge1) st = ST_UNF;
        else if (take && !jmp_ok) st = ST_JMP;
        else begin
          if (take) begin
            nxt = opd_r[PC_BITS-1:0]; jumped = 1'b1;
          end
          cnt_next = cnt_m1;
        end
      end
      OP_JMP: begin
        if (!jmp_ok) begin
          st = ST_JMP;
        end else begin
          nxt = opd_r[PC_BITS-1:0]; jumped = 1'b1;
        end
      end
      OP_HALT: st = ST_FIN;
      default: st = ST_UNK;
    endcase

    if (stopped) begin
      st = ST_STOP; pv = 1'b0; pval = '0; nxt = pc; cnt_next = count;
      x_we = 1'b0; x_w2 = 1'b0; div_go = 1'b0;
    end else if (st != ST_OK) begin
      pv = 1'b0; pval = '0; nxt = pc; cnt_next = count; stop_next = 1'b1;
      x_we = 1'b0; x_w2 = 1'b0; div_go = 1'b0;
    end else if (!jumped && WORD_BITS'(pc_inc) >= WORD_BITS'(prog_len)) begin
      st = ST_FIN; stop_next = 1'b1;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = x_addr;
    ram_wdata = x_data;
    unique case (state)
      S_EXEC: ram_we = x_we;
      S_DIV: begin
        ram_we    = div_done;
        ram_waddr = w2_addr;
        ram_wdata = (op_t'(op_r) == OP_MOD) ? div_r : div_q;
      end
      S_FIN: begin
        ram_we    = w2_pend;
        ram_waddr = w2_addr;
        ram_wdata = w2_data;
      end
      default: ram_we = 1'b0;
    endcase
  end

  assign req.ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      prog_len  <= {LEN_BITS{1'b1}};
      count     <= '0;
      pc        <= '0;
      stopped   <= 1'b0;
      w2_pend   <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_we) prog_len <= cfg_wdata;
      if (rsp.valid && rsp.ready && state != S_FIN) rsp.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_r  <= req.opcode;
            opd_r <= req.operand;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          count           <= cnt_next;
          pc              <= nxt;
          stopped         <= stop_next;
          res.status      <= st;
          res.print_valid <= pv;
          res.print_value <= pval;
          res.next_pc     <= LEN_BITS'(nxt);
          res.depth_now   <= DEPTH_BITS'(cnt_next);
          w2_pend         <= x_w2;
          w2_addr         <= div_go ? cnt_m2[SP_BITS-1:0] : x_w2_addr;
          w2_data         <= x_w2_data;
          state           <= div_go ? S_DIV : S_FIN;
        end
        S_DIV: begin
          if (div_done) state <= S_FIN;
        end
        S_FIN: begin
          w2_pend <= 1'b0;
          if (!rsp.valid || rsp.ready) begin
            rsp.valid       <= 1'b1;
            rsp.status      <= res.status;
            rsp.print_valid <= res.print_valid;
            rsp.print_value <= res.print_value;
            rsp.next_pc     <= res.next_pc;
            rsp.depth_now   <= res.depth_now;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SMX_ASSERT_IMP(a_count_bound, 1'b1, count <= CNT_BITS'(STACK_DEPTH), "stack count over depth")
  `SMX_ASSERT_NXT(a_stop_holds, stopped, stopped, "stopped flag cleared without reset")
  `SMX_ASSERT_IMP(a_rsp_from_fin, $rose(rsp.valid), $past(state == S_FIN), "result not from delivery")
  `SMX_ASSERT_IMP(a_div_in_div, div_busy || div_done, state == S_DIV, "divider active outside division")

endmodule

/* test/stack_machine_execute_unit_tb.sv */
// ----------------------------------------------------------------------------
// Stack machine execute unit testbench
// Runs a short directed instruction table, then error-free random programs
// over several program lengths with idle gaps on both channels, then stopping
// requests, each checked against a table value or an in-bench executor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stack_machine_execute_unit_tb;
  import smx_pkg::*;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [LEN_BITS-1:0] cfg_wdata;

  smx_req_if req_ch ();
  smx_rsp_if rsp_ch ();

  stack_machine_execute_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // executor state
  logic [WORD_BITS-1:0] stk [STACK_DEPTH];
  int unsigned stk_cnt;
  int unsigned exec_pc;
  int unsigned prog_len;
  bit halted;

  res_t pending_results [$];
  int fail_count;
  int checked_count;
  int sent_count;
  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_go;
  bit hold_done;
  int hold_left;

  typedef struct {
    logic [OP_BITS-1:0]   op;
    logic [WORD_BITS-1:0] opd;
    bit                   known;
    res_t                 res;
  } row_t;
  row_t dir_rows [$];

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #4000000;
    $display("[stack_machine_execute_unit] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_left <= 400;
      hold_done <= 1'b1;
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  function automatic res_t mk_res(status_t st, bit pv, logic [31:0] pval, int unsigned npc,
                                  int unsigned depth);
    res_t r;
    r.status = st;
    r.print_valid = pv;
    r.print_value = pval;
    r.next_pc = LEN_BITS'(npc);
    r.depth_now = DEPTH_BITS'(depth);
    return r;
  endfunction

  task automatic execute_instr(input logic [OP_BITS-1:0] op, input logic [WORD_BITS-1:0] opd,
                               output res_t r);
    status_t st;
    logic [31:0] a, b, val, t;
    int unsigned n, nxt;
    bit jumped, take, flag, pv;
    longint sa, sb;
    int ia, ib;
    st = ST_OK;
    n = stk_cnt;
    nxt = (exec_pc + 1) & 16'hFFFF;
    jumped = 0;
    pv = 0;
    val = '0;
    if (halted) begin
      r = mk_res(ST_STOP, 0, '0, exec_pc, stk_cnt);
      return;
    end
    a = (n >= 1) ? stk[n-1] : '0;
    b = (n >= 2) ? stk[n-2] : '0;
    case (op)
      OP_NOP: ;
      OP_PUSH: if (n >= STACK_DEPTH) st = ST_OVF; else begin stk[n] = opd; stk_cnt = n + 1; end
      OP_POP: if (n < 1) st = ST_UNF; else stk_cnt = n - 1;
      OP_PRINT: if (n < 1) st = ST_UNF; else begin pv = 1; val = a; end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
        if (n < 2) st = ST_UNF;
        else begin
          sa = $signed(a);
          sb = $signed(b);
          if (op == OP_ADD) t = a + b;
          else if (op == OP_SUB) t = b - a;
          else if (op == OP_MUL) t = a * b;
          else if (sa == 0) st = ST_DIVZ;
          else if (op == OP_DIV) t = 32'(sb / sa);
          else t = 32'(sb % sa);
          if (st == ST_OK) begin
            stk[n-2] = t;
            stk_cnt = n - 1;
          end
        end
      end
      OP_DUP: begin
        if (n < 1) st = ST_UNF;
        else if (n >= STACK_DEPTH) st = ST_OVF;
        else begin stk[n] = a; stk_cnt = n + 1; end
      end
      OP_DUPI: begin
        if (opd >= n) st = ST_IDX;
        else if (n >= STACK_DEPTH) st = ST_OVF;
        else begin stk[n] = stk[opd]; stk_cnt = n + 1; end
      end
      OP_SWAP: if (n < 2) st = ST_UNF; else begin stk[n-1] = b; stk[n-2] = a; end
      OP_SWAPI: begin
        if (opd >= n) st = ST_IDX;
        else begin
          t = stk[opd];
          stk[opd] = a;
          stk[n-1] = t;
        end
      end
      OP_CMPE, OP_CMPNE, OP_CMPG, OP_CMPL, OP_CMPGE, OP_CMPLE: begin
        ia = $signed(a);
        ib = $signed(b);
        if (n < 2) st = ST_UNF;
        else if (n >= STACK_DEPTH) st = ST_OVF;
        else begin
          case (op)
            OP_CMPE:  flag = (ia == ib);
            OP_CMPNE: flag = (ia != ib);
            OP_CMPG:  flag = (ia > ib);
            OP_CMPL:  flag = (ia < ib);
            OP_CMPGE: flag = (ia >= ib);
            default:  flag = (ia <= ib);
          endcase
          stk[n] = {31'd0, flag};
          stk_cnt = n + 1;
        end
      end
      OP_JZ, OP_JNZ, OP_JMP: begin
        take = 1;
        if (op != OP_JMP && n < 1) st = ST_UNF;
        else begin
          if (op == OP_JZ) take = (a == 0);
          else if (op == OP_JNZ) take = (a != 0);
          if (take && opd >= prog_len) st = ST_JMP;
          else begin
            if (take) begin
              nxt = opd & 16'hFFFF;
              jumped = 1;
            end
            if (op != OP_JMP) stk_cnt = n - 1;
          end
        end
      end
      OP_HALT: st = ST_FIN;
      default: st = ST_UNK;
    endcase
    if (st != ST_OK) begin
      nxt = exec_pc;
      halted = 1;
    end else if (!jumped && nxt >= prog_len) begin
      st = ST_FIN;
      halted = 1;
    end
    exec_pc = nxt;
    r = mk_res(st, pv, val, nxt, stk_cnt);
  endtask

  task automatic issue(input logic [OP_BITS-1:0] op, input logic [WORD_BITS-1:0] opd,
                       input bit known, input res_t kres);
    res_t r;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.operand <= opd;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    execute_instr(op, opd, r);
    pending_results.push_back(known ? kres : r);
    sent_count++;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5: return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  function automatic bit is_legal(logic [OP_BITS-1:0] op, logic [31:0] opd);
    int unsigned n;
    n = stk_cnt;
    case (op)
      OP_NOP, OP_JMP: return 1;
      OP_PUSH: return n < STACK_DEPTH;
      OP_POP, OP_PRINT, OP_JZ, OP_JNZ: return n >= 1;
      OP_ADD, OP_SUB, OP_MUL, OP_SWAP: return n >= 2;
      OP_DIV, OP_MOD: return n >= 2 && stk[n-1] != 0;
      OP_DUP: return n >= 1 && n < STACK_DEPTH;
      OP_DUPI: return opd < n && n < STACK_DEPTH;
      OP_SWAPI: return opd < n;
      OP_CMPE, OP_CMPNE, OP_CMPG, OP_CMPL, OP_CMPGE, OP_CMPLE:
        return n >= 2 && n < STACK_DEPTH;
      default: return 0;
    endcase
  endfunction

  // issue one instruction that keeps the machine running
  task automatic issue_running(input bit fill);
    logic [OP_BITS-1:0] op;
    logic [31:0] opd;
    bit ok;
    ok = 0;
    if (exec_pc + 1 >= prog_len) begin
      op = OP_JMP;
      opd = $urandom_range(0, prog_len - 2);
    end else begin
      while (!ok) begin
        op = fill ? OP_PUSH : OP_BITS'($urandom_range(OP_NOP, OP_JMP));
        case (op)
          OP_PUSH: opd = pick_word();
          OP_DUPI, OP_SWAPI: opd = (stk_cnt > 0) ? $urandom_range(0, stk_cnt - 1) : 0;
          OP_JZ, OP_JNZ, OP_JMP: opd = $urandom_range(0, prog_len - 2);
          default: opd = $urandom;
        endcase
        ok = is_legal(op, opd);
        if (!fill && stk_cnt > 40 && op inside {OP_PUSH, OP_DUP, OP_DUPI, OP_CMPE, OP_CMPNE,
            OP_CMPG, OP_CMPL, OP_CMPGE, OP_CMPLE} && $urandom_range(0, 1))
          ok = 0;
      end
    end
    issue(op, opd, 0, '0);
  endtask

  task automatic drain_and_write(input int unsigned len);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= LEN_BITS'(len);
    @(posedge clk);
    cfg_we <= 1'b0;
    prog_len = len;
  endtask

  task automatic add_row(input logic [OP_BITS-1:0] op, input logic [31:0] opd, input bit known,
                         input res_t kres);
    row_t row;
    row.op = op;
    row.opd = opd;
    row.known = known;
    row.res = kres;
    dir_rows.push_back(row);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      res_t exp_r;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d", $time, rsp_ch.status);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        checked_count++;
        if (rsp_ch.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, rsp_ch.status);
          fail_count++;
        end
        if (rsp_ch.print_valid !== exp_r.print_valid) begin
          $display("%0t: print_valid expected %0d actual %0d", $time, exp_r.print_valid,
                   rsp_ch.print_valid);
          fail_count++;
        end
        if (rsp_ch.print_value !== exp_r.print_value) begin
          $display("%0t: print_value expected %0d actual %0d", $time, exp_r.print_value,
                   rsp_ch.print_value);
          fail_count++;
        end
        if (rsp_ch.next_pc !== exp_r.next_pc) begin
          $display("%0t: next_pc expected %0d actual %0d", $time, exp_r.next_pc,
                   rsp_ch.next_pc);
          fail_count++;
        end
        if (rsp_ch.depth_now !== exp_r.depth_now) begin
          $display("%0t: depth_now expected %0d actual %0d", $time, exp_r.depth_now,
                   rsp_ch.depth_now);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int phase;
    int k;
    int phase_items;
    bit overflow_end;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.opcode = '0;
    req_ch.operand = '0;
    hold_go = 0;
    fail_count = 0;
    checked_count = 0;
    sent_count = 0;
    tx_idle_pct = 6;
    rx_idle_pct = 54;
    stk_cnt = 0;
    exec_pc = 0;
    prog_len = 65535;
    halted = 0;
    foreach (stk[i]) stk[i] = '0;

    add_row(OP_PUSH, 32'h7FFF_FFFF, 1, mk_res(ST_OK, 0, 0, 1, 1));
    add_row(OP_PUSH, 32'd1, 1, mk_res(ST_OK, 0, 0, 2, 2));
    add_row(OP_ADD, 0, 1, mk_res(ST_OK, 0, 0, 3, 1));
    add_row(OP_PRINT, 0, 1, mk_res(ST_OK, 1, 32'h8000_0000, 4, 1));
    add_row(OP_PUSH, 32'hFFFF_FFFF, 1, mk_res(ST_OK, 0, 0, 5, 2));
    add_row(OP_DIV, 0, 1, mk_res(ST_OK, 0, 0, 6, 1));
    add_row(OP_PRINT, 0, 1, mk_res(ST_OK, 1, 32'h8000_0000, 7, 1));
    add_row(OP_PUSH, 32'hFFFF_FFFF, 0, '0);
    add_row(OP_DUPI, 0, 0, '0);
    add_row(OP_SWAP, 0, 0, '0);
    add_row(OP_MOD, 0, 0, '0);
    add_row(OP_PUSH, -32'sd7, 0, '0);
    add_row(OP_PUSH, 32'd2, 0, '0);
    add_row(OP_DIV, 0, 0, '0);
    add_row(OP_SUB, 0, 0, '0);
    add_row(OP_MUL, 0, 0, '0);
    add_row(OP_DUP, 0, 0, '0);
    for (k = OP_CMPE; k <= OP_CMPLE; k++) add_row(OP_BITS'(k), 0, 0, '0);
    add_row(OP_SWAPI, 0, 0, '0);
    add_row(OP_JZ, 32'd65532, 0, '0);
    add_row(OP_JNZ, 32'd65532, 0, '0);
    add_row(OP_POP, 0, 0, '0);
    add_row(OP_NOP, 0, 0, '0);
    add_row(OP_JMP, 0, 0, '0);

    // an overflow ending spends most of the budget on filling the stack
    overflow_end = ($urandom_range(0, 2) == 0);
    phase_items = overflow_end ? 10 : 340;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) issue(dir_rows[i].op, dir_rows[i].opd, dir_rows[i].known,
                                dir_rows[i].res);

    for (phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 54 : 0;
      rx_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 6 : 0;
      if (!halted && exec_pc != 0) issue(OP_JMP, 0, 0, '0);
      drain_and_write((phase == 0) ? 300 : (phase == 1) ? 65535 : 1000);
      if (phase == 2) hold_go = 1;
      for (k = 0; k < phase_items; k++) issue_running(0);
    end

    // finish on a stopping instruction, sometimes by filling the stack first
    if (overflow_end) begin
      while (stk_cnt < STACK_DEPTH) issue_running(1);
      issue(OP_PUSH, $urandom, 0, '0);
    end
    drain_and_write(0);
    issue(OP_BITS'($urandom_range(0, 31)), $urandom, 0, '0);
    for (k = 0; k < 5; k++) issue(OP_BITS'($urandom_range(0, 31)), $urandom, 0, '0);
    req_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Executed %0d instructions, %0d results checked, stack overflow ending: %0d",
             sent_count, checked_count, overflow_end);
    $display("Program lengths 65535, 300, 1000 and 0 used; %0d mismatches", fail_count);
    if (fail_count == 0)
      $display("[stack_machine_execute_unit] OK");
    else
      $display("[stack_machine_execute_unit] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/smx_pkg.sv
hw/rtl/smx_if.sv
hw/rtl/smx_stack_ram.sv
hw/rtl/smx_div.sv
hw/rtl/stack_machine_execute_unit.sv
test/stack_machine_execute_unit_tb.sv
